### sv/skjw_pkg.sv
package skjw_pkg;

	localparam int WORD_W = 32;

	// request codes
	localparam logic [1:0] REQ_LOAD_IB   = 2'd0;
	localparam logic [1:0] REQ_LOAD_ROOT = 2'd1;
	localparam logic [1:0] REQ_PROCESS   = 2'd2;
	localparam logic [1:0] REQ_NONE      = 2'd3;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [7:0]               joint_index;
		logic [7:0]               parent_index;
		logic [1:0]               row_index;
		logic signed [WORD_W-1:0] word_a;
		logic signed [WORD_W-1:0] word_b;
		logic signed [WORD_W-1:0] word_c;
		logic signed [WORD_W-1:0] word_d;
		logic signed [WORD_W-1:0] trans_x;
		logic signed [WORD_W-1:0] trans_y;
		logic signed [WORD_W-1:0] trans_z;
	} in_t;

	typedef struct packed {
		logic [7:0]               out_joint;
		logic [1:0]               out_row;
		logic signed [WORD_W-1:0] out_a;
		logic signed [WORD_W-1:0] out_b;
		logic signed [WORD_W-1:0] out_c;
		logic signed [WORD_W-1:0] out_d;
		logic                     last_row;
		logic                     order_error;
	} out_t;

	// one matrix row, element e at [e]
	typedef logic [3:0][WORD_W-1:0] row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOCAL,
		ST_BUILD,
		ST_FETCH,
		ST_MUL1,
		ST_STORE,
		ST_MUL2,
		ST_EMIT
	} state_t;

	// tag that follows a product through the multiplier
	typedef struct packed {
		logic       valid;
		logic [5:0] idx;
	} mac_tag_t;

endpackage

### sv/skjw_ram.sv
module skjw_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/skjw_mac.sv
module skjw_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skjw_pkg::mac_tag_t                  tag_in,
	input  logic signed [skjw_pkg::WORD_W-1:0]  op_a,
	input  logic signed [skjw_pkg::WORD_W-1:0]  op_b,
	output skjw_pkg::mac_tag_t                  tag_out,
	output logic signed [64-FRAC_BITS-1:0]      res
);

	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	skjw_pkg::mac_tag_t tag_s1, tag_s2;
	logic signed [63:0] prod_s1;
	logic signed [63:0] rnd;
	logic signed [64-FRAC_BITS-1:0] res_s2;

	// exact product, then round half up with floor shift
	assign rnd = (prod_s1 + HALF) >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(op_a) * 64'(op_b);
		res_s2  <= rnd[64-FRAC_BITS-1:0];
	end

	assign tag_out = tag_s2;
	assign res     = res_s2;

endmodule

### sv/skeleton_joint_world_matrix_unit.sv
// channel | dir | handshake            | word
// in      | in  | in_valid / in_ready  | skjw_pkg::in_t  (load row or joint)
// out     | out | out_valid / out_ready| skjw_pkg::out_t (skinning row)
//
// loads leave the block idle; a joint keeps the input busy from its accept until
// its last row is loaded for output (joint zero skips the parent fetch, and a
// bad-order joint goes straight to emit); the work runs on the single shared multiplier:
// 9 rotation products plus two 64-product matrix multiplies, each through the
// two-stage multiply/round pipeline; a stalled output stretches the emit phase
// asynchronous reset clears control and sets the root transform to identity
// stores of world and inverse-bind rows have no reset
// results wait in an output register; the block returns to idle once the
// last row is loaded there
module skeleton_joint_world_matrix_unit #(
	parameter int MAX_JOINTS = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  skjw_pkg::in_t  in_word,
	output logic           out_valid,
	input  logic           out_ready,
	output skjw_pkg::out_t out_word
);

	localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int DEPTH = MAX_JOINTS * 4;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = 64 - FRAC_BITS;
	localparam int EW    = RW + 3;
	localparam int WW    = skjw_pkg::WORD_W;
	localparam logic signed [EW-1:0] ONE_E  = EW'(1) <<< FRAC_BITS;
	localparam logic signed [EW-1:0] SAT_HI = EW'(64'sd2147483647);
	localparam logic signed [EW-1:0] SAT_LO = EW'(-64'sd2147483648);

	function automatic logic signed [WW-1:0] sat32(input logic signed [EW-1:0] v);
		if (v > SAT_HI) begin
			return 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			return 32'sh80000000;
		end
		return v[WW-1:0];
	endfunction

	skjw_pkg::state_t state_q, state_d;
	logic [6:0] cnt_q;
	skjw_pkg::in_t item_q;
	logic err_q;

	// rotation products xx yy zz xy xz yz wx wy wz
	logic signed [RW-1:0] lp_q [9];
	// operand matrices and result matrix, row-major
	logic signed [WW-1:0] ma_q [16];
	logic signed [WW-1:0] mb_q [16];
	logic signed [WW-1:0] mc_q [16];
	logic signed [WW-1:0] root_q [16];
	logic signed [WW-1:0] loc [16];
	logic signed [EW-1:0] acc_q;
	logic signed [EW-1:0] acc_sum;

	skjw_pkg::out_t out_q;
	logic out_valid_q;

	logic accept, in_range, proc_ok, bad_order, emit_load;
	skjw_pkg::mac_tag_t mac_in, mac_out;
	logic signed [WW-1:0] op_a, op_b;
	logic signed [RW-1:0] mac_res;

	logic wm_we, ib_we;
	logic [AW-1:0] wm_waddr, wm_raddr, ib_waddr, ib_raddr;
	skjw_pkg::row_t wm_wdata, wm_rdata, ib_wdata, ib_rdata;
	logic [1:0] fill_row;

	assign accept    = in_valid && in_ready;
	assign in_range  = 32'(in_word.joint_index) < MAX_JOINTS;
	assign proc_ok   = in_range && (in_word.req_type == skjw_pkg::REQ_PROCESS);
	assign bad_order = (in_word.joint_index != 8'd0) &&
		(in_word.parent_index >= in_word.joint_index);
	assign fill_row  = 2'(cnt_q - 7'd1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skjw_pkg::ST_IDLE: begin
				if (accept && proc_ok) begin
					state_d = bad_order ? skjw_pkg::ST_EMIT : skjw_pkg::ST_LOCAL;
				end
			end
			skjw_pkg::ST_LOCAL: if (cnt_q == 7'd10) state_d = skjw_pkg::ST_BUILD;
			skjw_pkg::ST_BUILD: begin
				state_d = (item_q.joint_index == 8'd0) ? skjw_pkg::ST_MUL1
					: skjw_pkg::ST_FETCH;
			end
			skjw_pkg::ST_FETCH: if (cnt_q == 7'd4) state_d = skjw_pkg::ST_MUL1;
			skjw_pkg::ST_MUL1:  if (cnt_q == 7'd65) state_d = skjw_pkg::ST_STORE;
			skjw_pkg::ST_STORE: if (cnt_q == 7'd4) state_d = skjw_pkg::ST_MUL2;
			skjw_pkg::ST_MUL2:  if (cnt_q == 7'd65) state_d = skjw_pkg::ST_EMIT;
			skjw_pkg::ST_EMIT:  if (emit_load && cnt_q == 7'd3) state_d = skjw_pkg::ST_IDLE;
			default: state_d = skjw_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready   = (state_q == skjw_pkg::ST_IDLE);
		emit_load  = (state_q == skjw_pkg::ST_EMIT) && (!out_valid_q || out_ready);
		mac_in     = '0;
		mac_in.idx = cnt_q[5:0];
		op_a       = ma_q[{cnt_q[5:4], cnt_q[1:0]}];
		op_b       = mb_q[{cnt_q[1:0], cnt_q[3:2]}];
		ib_we      = accept && in_range && (in_word.req_type == skjw_pkg::REQ_LOAD_IB);
		ib_waddr   = {JW'(in_word.joint_index), in_word.row_index};
		ib_wdata   = {in_word.word_d, in_word.word_c, in_word.word_b, in_word.word_a};
		ib_raddr   = {JW'(item_q.joint_index), cnt_q[1:0]};
		wm_we      = (state_q == skjw_pkg::ST_STORE) && (cnt_q < 7'd4);
		wm_waddr   = {JW'(item_q.joint_index), cnt_q[1:0]};
		wm_wdata   = {mc_q[{cnt_q[1:0], 2'd3}], mc_q[{cnt_q[1:0], 2'd2}],
			mc_q[{cnt_q[1:0], 2'd1}], mc_q[{cnt_q[1:0], 2'd0}]};
		wm_raddr   = {JW'(item_q.parent_index), cnt_q[1:0]};
		unique case (state_q)
			skjw_pkg::ST_LOCAL: mac_in.valid = (cnt_q < 7'd9);
			skjw_pkg::ST_MUL1, skjw_pkg::ST_MUL2: mac_in.valid = (cnt_q < 7'd64);
			default: mac_in.valid = 1'b0;
		endcase
		if (state_q == skjw_pkg::ST_LOCAL) begin
			// rotation product table
			unique case (cnt_q[3:0])
				4'd0: begin op_a = item_q.word_b; op_b = item_q.word_b; end
				4'd1: begin op_a = item_q.word_c; op_b = item_q.word_c; end
				4'd2: begin op_a = item_q.word_d; op_b = item_q.word_d; end
				4'd3: begin op_a = item_q.word_b; op_b = item_q.word_c; end
				4'd4: begin op_a = item_q.word_b; op_b = item_q.word_d; end
				4'd5: begin op_a = item_q.word_c; op_b = item_q.word_d; end
				4'd6: begin op_a = item_q.word_a; op_b = item_q.word_b; end
				4'd7: begin op_a = item_q.word_a; op_b = item_q.word_c; end
				4'd8: begin op_a = item_q.word_a; op_b = item_q.word_d; end
				default: begin op_a = item_q.word_a; op_b = item_q.word_a; end
			endcase
		end
	end

	// local rigid matrix from the rotation products
	always_comb begin
		logic signed [EW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
		xx = EW'(lp_q[0]); yy = EW'(lp_q[1]); zz = EW'(lp_q[2]);
		xy = EW'(lp_q[3]); xz = EW'(lp_q[4]); yz = EW'(lp_q[5]);
		wx = EW'(lp_q[6]); wy = EW'(lp_q[7]); wz = EW'(lp_q[8]);
		loc[0]  = sat32(ONE_E - ((yy + zz) <<< 1));
		loc[1]  = sat32((xy - wz) <<< 1);
		loc[2]  = sat32((xz + wy) <<< 1);
		loc[3]  = item_q.trans_x;
		loc[4]  = sat32((xy + wz) <<< 1);
		loc[5]  = sat32(ONE_E - ((xx + zz) <<< 1));
		loc[6]  = sat32((yz - wx) <<< 1);
		loc[7]  = item_q.trans_y;
		loc[8]  = sat32((xz - wy) <<< 1);
		loc[9]  = sat32((yz + wx) <<< 1);
		loc[10] = sat32(ONE_E - ((xx + yy) <<< 1));
		loc[11] = item_q.trans_z;
		loc[12] = '0;
		loc[13] = '0;
		loc[14] = '0;
		loc[15] = WW'(ONE_E);
	end

	// running sum of four rounded products
	assign acc_sum = ((mac_out.idx[1:0] == 2'd0) ? '0 : acc_q) + EW'(mac_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skjw_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				root_q[i] <= (i % 5 == 0) ? WW'(ONE_E) : '0;
			end
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == skjw_pkg::ST_EMIT) begin
				cnt_q <= cnt_q + 7'(emit_load);
			end else begin
				cnt_q <= cnt_q + 7'd1;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && in_word.req_type == skjw_pkg::REQ_LOAD_ROOT) begin
				root_q[{in_word.row_index, 2'd0}] <= in_word.word_a;
				root_q[{in_word.row_index, 2'd1}] <= in_word.word_b;
				root_q[{in_word.row_index, 2'd2}] <= in_word.word_c;
				root_q[{in_word.row_index, 2'd3}] <= in_word.word_d;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_word;
			err_q  <= bad_order;
			if (proc_ok && bad_order) begin
				for (int i = 0; i < 16; i++) mc_q[i] <= '0;
			end
		end
		if (state_q == skjw_pkg::ST_LOCAL && mac_out.valid) begin
			lp_q[mac_out.idx[3:0]] <= mac_res;
		end
		if (state_q == skjw_pkg::ST_BUILD) begin
			for (int i = 0; i < 16; i++) mb_q[i] <= loc[i];
			if (item_q.joint_index == 8'd0) begin
				for (int i = 0; i < 16; i++) ma_q[i] <= root_q[i];
			end
		end
		if (state_q == skjw_pkg::ST_FETCH && cnt_q != 7'd0) begin
			for (int e = 0; e < 4; e++) ma_q[{fill_row, 2'(e)}] <= wm_rdata[e];
		end
		if (state_q == skjw_pkg::ST_STORE) begin
			if (cnt_q == 7'd0) begin
				for (int i = 0; i < 16; i++) ma_q[i] <= mc_q[i];
			end else begin
				for (int e = 0; e < 4; e++) mb_q[{fill_row, 2'(e)}] <= ib_rdata[e];
			end
		end
		if ((state_q == skjw_pkg::ST_MUL1 || state_q == skjw_pkg::ST_MUL2) && mac_out.valid) begin
			if (mac_out.idx[1:0] == 2'd3) begin
				mc_q[mac_out.idx[5:2]] <= sat32(acc_sum);
			end
			acc_q <= acc_sum;
		end
		if (emit_load) begin
			// row k of the transpose is column k
			out_q.out_joint   <= item_q.joint_index;
			out_q.out_row     <= cnt_q[1:0];
			out_q.out_a       <= mc_q[{2'd0, cnt_q[1:0]}];
			out_q.out_b       <= mc_q[{2'd1, cnt_q[1:0]}];
			out_q.out_c       <= mc_q[{2'd2, cnt_q[1:0]}];
			out_q.out_d       <= mc_q[{2'd3, cnt_q[1:0]}];
			out_q.last_row    <= (cnt_q[1:0] == 2'd3);
			out_q.order_error <= err_q;
		end
	end

	skjw_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (mac_in),
		.op_a    (op_a),
		.op_b    (op_b),
		.tag_out (mac_out),
		.res     (mac_res)
	);

	skjw_ram #(.WIDTH(4 * WW), .DEPTH(DEPTH)) u_world_ram (
		.clk   (clk),
		.we    (wm_we),
		.waddr (wm_waddr),
		.wdata (wm_wdata),
		.raddr (wm_raddr),
		.rdata (wm_rdata)
	);

	skjw_ram #(.WIDTH(4 * WW), .DEPTH(DEPTH)) u_ibind_ram (
		.clk   (clk),
		.we    (ib_we),
		.waddr (ib_waddr),
		.wdata (ib_wdata),
		.raddr (ib_raddr),
		.rdata (ib_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### sv/skjw_checker.sv
module skjw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input skjw_pkg::in_t  in_word,
	input logic           out_valid,
	input logic           out_ready,
	input skjw_pkg::out_t out_word
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.last_row == (out_word.out_row == 2'd3)))
		else $error("last_row does not match row three");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.order_error |-> out_word.out_joint != 8'd0 &&
			out_word.out_a == '0 && out_word.out_b == '0 &&
			out_word.out_c == '0 && out_word.out_d == '0)
		else $error("order error row is not zero");

	// joint zero always starts a multi-cycle job
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_word.req_type == skjw_pkg::REQ_PROCESS &&
			in_word.joint_index == 8'd0 |=> !in_ready)
		else $error("ready right after a joint was taken");

endmodule

bind skeleton_joint_world_matrix_unit skjw_checker u_skjw_checker (.*);

### bench/tb_skeleton_joint_world_matrix_unit.sv
module tb_skeleton_joint_world_matrix_unit;

	localparam int NJ        = 256;
	localparam int FRAC      = 16;
	localparam int CYC_LIMIT = 400000;
	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	// skinning-row scoreboard with its own copy of the skeleton state
	class skin_board;
		logic signed [31:0] world_mat [NJ][16];
		logic signed [31:0] inv_bind [NJ][16];
		logic signed [31:0] root_mat [16];
		skjw_pkg::out_t pending [$];
		int errors;

		function new();
			errors = 0;
			for (int i = 0; i < 16; i++)
				root_mat[i] = (i % 5 == 0) ? Q_ONE : 32'sd0;
		endfunction

		// rounded fixed-point product, floor after adding half an lsb
		function longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
			longint p;
			p = longint'(a) * longint'(b) + (longint'(1) << (FRAC - 1));
			return p >>> FRAC;
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function void mat_mul(logic signed [31:0] a [16], logic signed [31:0] b [16],
				output logic signed [31:0] c [16]);
			longint s;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++) begin
					s = 0;
					for (int k = 0; k < 4; k++) s += fx_mul(a[i*4+k], b[k*4+j]);
					c[i*4+j] = clamp32(s);
				end
		endfunction

		// note an accepted input word and queue the rows it should produce
		function void note_word(skjw_pkg::in_t w);
			logic signed [31:0] loc [16], wm [16], pm [16], sk [16];
			longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
			logic bad;
			skjw_pkg::out_t o;
			case (w.req_type)
				skjw_pkg::REQ_LOAD_IB: begin
					inv_bind[w.joint_index][w.row_index*4+0] = w.word_a;
					inv_bind[w.joint_index][w.row_index*4+1] = w.word_b;
					inv_bind[w.joint_index][w.row_index*4+2] = w.word_c;
					inv_bind[w.joint_index][w.row_index*4+3] = w.word_d;
				end
				skjw_pkg::REQ_LOAD_ROOT: begin
					root_mat[w.row_index*4+0] = w.word_a;
					root_mat[w.row_index*4+1] = w.word_b;
					root_mat[w.row_index*4+2] = w.word_c;
					root_mat[w.row_index*4+3] = w.word_d;
				end
				skjw_pkg::REQ_PROCESS: begin
					bad = (w.joint_index != 0) && (w.parent_index >= w.joint_index);
					if (bad) begin
						for (int i = 0; i < 16; i++) sk[i] = '0;
					end else begin
						xx = fx_mul(w.word_b, w.word_b); yy = fx_mul(w.word_c, w.word_c);
						zz = fx_mul(w.word_d, w.word_d); xy = fx_mul(w.word_b, w.word_c);
						xz = fx_mul(w.word_b, w.word_d); yz = fx_mul(w.word_c, w.word_d);
						wx = fx_mul(w.word_a, w.word_b); wy = fx_mul(w.word_a, w.word_c);
						wz = fx_mul(w.word_a, w.word_d);
						loc[0]  = clamp32(longint'(Q_ONE) - 2 * (yy + zz));
						loc[1]  = clamp32(2 * (xy - wz));
						loc[2]  = clamp32(2 * (xz + wy));
						loc[3]  = w.trans_x;
						loc[4]  = clamp32(2 * (xy + wz));
						loc[5]  = clamp32(longint'(Q_ONE) - 2 * (xx + zz));
						loc[6]  = clamp32(2 * (yz - wx));
						loc[7]  = w.trans_y;
						loc[8]  = clamp32(2 * (xz - wy));
						loc[9]  = clamp32(2 * (yz + wx));
						loc[10] = clamp32(longint'(Q_ONE) - 2 * (xx + yy));
						loc[11] = w.trans_z;
						loc[12] = '0; loc[13] = '0; loc[14] = '0; loc[15] = Q_ONE;
						if (w.joint_index == 0) pm = root_mat;
						else pm = world_mat[w.parent_index];
						mat_mul(pm, loc, wm);
						world_mat[w.joint_index] = wm;
						mat_mul(wm, inv_bind[w.joint_index], sk);
					end
					// row k of the transpose is column k of the skinning matrix
					for (int k = 0; k < 4; k++) begin
						o.out_joint   = w.joint_index;
						o.out_row     = 2'(k);
						o.out_a       = sk[k];
						o.out_b       = sk[4+k];
						o.out_c       = sk[8+k];
						o.out_d       = sk[12+k];
						o.last_row    = (k == 3);
						o.order_error = bad;
						pending.push_back(o);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_row(skjw_pkg::out_t got);
			skjw_pkg::out_t exp_row;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected row %p", got);
				return;
			end
			exp_row = pending.pop_front();
			if (got !== exp_row) begin
				errors++;
				if (errors <= 10) $display("row mismatch: expected %p actual %p", exp_row, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	skjw_pkg::in_t in_word = '0;
	logic out_valid;
	logic out_ready = 0;
	skjw_pkg::out_t out_word;

	skin_board board = new();
	int cycles = 0;
	bit out_hold = 0;
	// loaded inverse-bind rows, and joints whose world matrix is defined
	bit ib_rows [NJ][4];
	bit posed [NJ];

	skeleton_joint_world_matrix_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random ready stalls, check at each accepted row
	int stall_left = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) board.check_row(out_word);
		if (out_hold) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// present one word and hold it until accepted, after a random gap;
	// valid drops only when a gap or a wait follows
	task automatic send_word(skjw_pkg::in_t w, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		board.note_word(w);
		if (w.req_type == skjw_pkg::REQ_LOAD_IB && w.joint_index < NJ)
			ib_rows[w.joint_index][w.row_index] = 1;
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return Q_ONE;
			3: return -Q_ONE;
			default: return $signed($urandom());
		endcase
	endfunction

	// mostly near-unit quaternion components, sometimes extreme
	function automatic logic signed [31:0] quat_part();
		if ($urandom_range(0, 9) == 0) return rand_word();
		return $signed($urandom_range(0, 131072)) - 32'sd65536;
	endfunction

	function automatic skjw_pkg::in_t row_word(logic [1:0] kind, logic [7:0] j, logic [1:0] r);
		skjw_pkg::in_t w;
		w = '0;
		w.req_type = kind; w.joint_index = j; w.row_index = r;
		w.parent_index = 8'($urandom());
		w.word_a = rand_word(); w.word_b = rand_word();
		w.word_c = rand_word(); w.word_d = rand_word();
		w.trans_x = $urandom(); w.trans_y = $urandom(); w.trans_z = $urandom();
		if ($urandom_range(0, 2) != 0) begin
			// small values keep sums away from saturation
			w.word_a = $signed($urandom_range(0, 262144)) - 32'sd131072;
			w.word_b = $signed($urandom_range(0, 262144)) - 32'sd131072;
			w.word_c = $signed($urandom_range(0, 262144)) - 32'sd131072;
			w.word_d = $signed($urandom_range(0, 262144)) - 32'sd131072;
		end
		return w;
	endfunction

	task automatic load_ib(logic [7:0] j);
		for (int r = 0; r < 4; r++) send_word(row_word(skjw_pkg::REQ_LOAD_IB, j, 2'(r)));
	endtask

	// process a joint; a sound request only names a defined parent
	task automatic joint_word(logic [7:0] j, logic [7:0] p, bit extreme = 0);
		skjw_pkg::in_t w;
		bit good;
		w = row_word(skjw_pkg::REQ_PROCESS, j, 2'($urandom()));
		w.parent_index = p;
		if (!extreme) begin
			w.word_a = quat_part(); w.word_b = quat_part();
			w.word_c = quat_part(); w.word_d = quat_part();
		end
		good = (j == 0) || (p < j);
		send_word(w);
		if (good) posed[j] = 1;
	endtask

	function automatic bit ib_ready(int j);
		return ib_rows[j][0] && ib_rows[j][1] && ib_rows[j][2] && ib_rows[j][3];
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	int j, p, pick, sent;
	skjw_pkg::in_t w;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: root rows, extreme root entries, then a short chain
		for (int r = 0; r < 4; r++)
			send_word(row_word(skjw_pkg::REQ_LOAD_ROOT, 8'($urandom()), 2'(r)));
		load_ib(8'd0); load_ib(8'd1); load_ib(8'd255);
		joint_word(8'd0, 8'hff, 1);       // extreme quaternion, parent ignored
		joint_word(8'd1, 8'd0);
		joint_word(8'd1, 8'd1);           // parent equal to joint
		joint_word(8'd1, 8'd200);         // parent above joint
		joint_word(8'd255, 8'd1);
		joint_word(8'd255, 8'd254);       // good order, parent 254 never processed
		w = row_word(skjw_pkg::REQ_NONE, 8'd0, 2'd0);  // unused request type
		send_word(w);
		for (int r = 0; r < 4; r++) send_word(row_word(skjw_pkg::REQ_LOAD_ROOT, 8'd0, 2'(r)));
		joint_word(8'd0, 8'd0);

		// pause the sender until every row has come back
		wait_drained();
		// hold results back while the next joint is queued
		out_hold = 1;
		joint_word(8'd1, 8'd0);
		in_valid <= 1'b0;
		repeat (200) @(posedge clk);
		out_hold = 0;
		wait_drained();

		// random: well-formed skeleton walks with some noise
		sent = 0;
		while (sent < 500) begin
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				j = $urandom_range(0, 255);
				load_ib(8'(j));
				sent += 4;
			end else if (pick == 3) begin
				send_word(row_word(skjw_pkg::REQ_LOAD_ROOT, 8'($urandom()), 2'($urandom())));
				sent++;
			end else if (pick == 4) begin
				// bad order on any nonzero joint, needs nothing defined
				j = $urandom_range(1, 255);
				joint_word(8'(j), 8'($urandom_range(j, 255)), 1'($urandom_range(0, 1)));
				sent++;
			end else if (pick == 5) begin
				send_word(row_word(skjw_pkg::REQ_NONE, 8'($urandom()), 2'($urandom())));
			end else begin
				j = $urandom_range(0, 255);
				if (!ib_ready(j)) begin
					load_ib(8'(j));
					sent += 4;
				end
				if (j == 0) begin
					joint_word(8'd0, 8'($urandom()), $urandom_range(0, 7) == 0);
				end else begin
					p = $urandom_range(0, j - 1);
					// find a posed parent below the joint, else fall back to root
					while (p > 0 && !posed[p]) p--;
					if (!posed[p]) begin
						if (!ib_ready(0)) load_ib(8'd0);
						joint_word(8'd0, 8'($urandom()));
						p = 0;
					end
					joint_word(8'(j), 8'(p), $urandom_range(0, 15) == 0);
				end
				sent++;
			end
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
sv/skjw_pkg.sv
sv/skjw_ram.sv
sv/skjw_mac.sv
sv/skeleton_joint_world_matrix_unit.sv
sv/skjw_checker.sv
bench/tb_skeleton_joint_world_matrix_unit.sv
